// ----- rtl/lzt_pkg.sv -----
// ----------------------------------------------------------------------------
// lzt_pkg
// Shared constants and controller/datapath handshake types for the LZ77
// match tokenizer.
// ----------------------------------------------------------------------------
package lzt_pkg;

  localparam int unsigned WINDOW_DEF    = 4096;
  localparam int unsigned MAX_MATCH_DEF = 257;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch incoming item, arm sweep
    logic step;     // issue one distance of the sweep
    logic finish;   // commit token state, load output
  } lzt_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic sweep_end;     // distance 1 is being issued
    logic emit_blocked;  // a token is due but the output register is full
  } lzt_sts_t;

endpackage

// ----- rtl/lzt_ctrl.sv -----
// ----------------------------------------------------------------------------
// lzt_ctrl
// Sequencer: accept an item, sweep all distances, drain the compare stage,
// then commit and, when a token is due, hand it to the output register.
// ----------------------------------------------------------------------------
module lzt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lzt_pkg::lzt_sts_t sts,
  output lzt_pkg::lzt_cmd_t cmd
);
  import lzt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SWEEP = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.step    = 1'b0;
    cmd.finish  = 1'b0;
    in_ready    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_SWEEP;
        end
      end
      S_SWEEP: begin
        cmd.step = 1'b1;
        if (sts.sweep_end) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold until the output register can take the token
        if (!sts.emit_blocked) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/lzt_datapath.sv -----
// ----------------------------------------------------------------------------
// lzt_datapath
// History ring, per-distance candidate flags, match state and the output
// register. One distance is compared per cycle behind a registered read.
// ----------------------------------------------------------------------------
module lzt_datapath #(
  parameter int unsigned WINDOW    = lzt_pkg::WINDOW_DEF,
  parameter int unsigned MAX_MATCH = lzt_pkg::MAX_MATCH_DEF,
  parameter int unsigned DW        = $clog2(WINDOW + 1),
  parameter int unsigned LW        = $clog2(MAX_MATCH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  lzt_pkg::lzt_cmd_t cmd,
  output lzt_pkg::lzt_sts_t sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DW-1:0]     match_offset,
  output logic [LW-1:0]     match_length,
  output logic [7:0]        next_literal,
  output logic              ends_input
);
  import lzt_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW);
  localparam int unsigned SW = $clog2(WINDOW + MAX_MATCH + 2);
  localparam logic [DW-1:0] WIN  = DW'(WINDOW);
  localparam logic [LW-1:0] MAXL = LW'(MAX_MATCH);

  logic [7:0]    hist  [WINDOW];
  logic          alive [WINDOW];

  logic [AW-1:0] wp;
  logic [DW-1:0] bytes_seen;
  logic [LW-1:0] cur_len;
  logic [DW-1:0] best_dist;

  logic [7:0]    b_r;
  logic          last_r;
  logic [DW-1:0] d;
  logic          any;
  logic [DW-1:0] best;

  logic          p_vld;
  logic [DW-1:0] p_d;
  logic [7:0]    hist_q;
  logic          alive_q;

  logic [DW-1:0] wp_ext;
  logic [DW-1:0] rd_full;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] d_idx;
  logic [AW-1:0] p_idx;
  logic          cand;
  logic          keep;
  logic          produce;
  logic [SW-1:0] seen_sum;
  logic [LW-1:0] len_inc;

  assign wp_ext  = DW'(wp);
  assign rd_full = (wp_ext >= d) ? (wp_ext - d) : (wp_ext + WIN - d);
  assign rd_addr = rd_full[AW-1:0];
  assign d_idx   = AW'(d - DW'(1));
  assign p_idx   = AW'(p_d - DW'(1));

  assign cand = (cur_len == '0) ? (p_d <= bytes_seen) : alive_q;
  assign keep = (cur_len < MAXL) && cand && (p_d > DW'(cur_len)) && (hist_q == b_r);

  assign produce  = !any || last_r;
  assign seen_sum = SW'(bytes_seen) + SW'(cur_len) + SW'(1);
  assign len_inc  = cur_len + LW'(1);

  assign sts.sweep_end    = (d == DW'(1));
  assign sts.emit_blocked = produce && out_valid && !out_ready;

  // memories: registered reads during the sweep, writes at compare and commit
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      hist_q  <= hist[rd_addr];
      alive_q <= alive[d_idx];
    end
    if (p_vld) begin
      alive[p_idx] <= keep;
    end
    if (cmd.finish && !last_r) begin
      hist[wp] <= b_r;
    end
  end

  // sweep payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      b_r    <= data_byte;
      last_r <= last_byte;
      d      <= WIN;
    end else if (cmd.step) begin
      d <= d - DW'(1);
    end
    if (cmd.step) begin
      p_d <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
      any   <= 1'b0;
      best  <= '0;
    end else begin
      p_vld <= cmd.step;
      if (cmd.capture) begin
        any  <= 1'b0;
        best <= '0;
      end else if (p_vld && keep && !any) begin
        // oldest surviving candidate wins
        any  <= 1'b1;
        best <= p_d;
      end
    end
  end

  // token state
  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      bytes_seen <= '0;
      cur_len    <= '0;
      best_dist  <= '0;
    end else if (cmd.finish) begin
      if (last_r) begin
        wp         <= '0;
        bytes_seen <= '0;
        cur_len    <= '0;
        best_dist  <= '0;
      end else begin
        if (any) begin
          cur_len   <= len_inc;
          best_dist <= best;
        end else begin
          cur_len    <= '0;
          best_dist  <= '0;
          bytes_seen <= (seen_sum > SW'(WINDOW)) ? WIN : DW'(seen_sum);
        end
        wp <= (wp == AW'(WINDOW - 1)) ? '0 : wp + AW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish && produce) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && produce) begin
      if (any) begin
        match_offset <= best;
        match_length <= len_inc;
        next_literal <= '0;
        ends_input   <= 1'b1;
      end else begin
        match_offset <= (cur_len == '0) ? '0 : best_dist;
        match_length <= cur_len;
        next_literal <= b_r;
        ends_input   <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/lz77_match_tokenizer.sv -----
// Flow: an accepted item is swept over all distances, one history and
//   candidate-flag memory read per cycle, then the compare stage drains and
//   any due token waits for the output register; then the next item is taken.
// Reset: synchronous; clears match state, write pointer and handshakes.
//   History and candidate flags need no clearing pass.
// ----------------------------------------------------------------------------
// lz77_match_tokenizer
// Greedy LZ77 tokenizer: bytes in, (offset, length, literal/end) tokens out.
// ----------------------------------------------------------------------------
module lz77_match_tokenizer #(
  parameter int unsigned WINDOW    = lzt_pkg::WINDOW_DEF,
  parameter int unsigned MAX_MATCH = lzt_pkg::MAX_MATCH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     data_byte,
  input  logic                           last_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [$clog2(WINDOW+1)-1:0]    match_offset,
  output logic [$clog2(MAX_MATCH+1)-1:0] match_length,
  output logic [7:0]                     next_literal,
  output logic                           ends_input
);
  import lzt_pkg::*;

  lzt_cmd_t cmd;
  lzt_sts_t sts;

  lzt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzt_datapath #(
    .WINDOW    (WINDOW),
    .MAX_MATCH (MAX_MATCH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .match_offset (match_offset),
    .match_length (match_length),
    .next_literal (next_literal),
    .ends_input   (ends_input)
  );

endmodule
